### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/lkv_pkg.sv
// Package for the LRU key/value cache: sizes, request codes, cell types.
package lkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 64;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int CFG_W      = 5;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [CFG_W-1:0]    CAP_RESET   = CFG_W'(16);
	localparam logic [ADDR_W-3:0]   REG_CAP_IDX = '0;

	typedef enum logic [1:0] {
		REQ_GET   = 2'd0,
		REQ_PUT   = 2'd1,
		REQ_PROBE = 2'd2,
		REQ_FLUSH = 2'd3
	} req_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic upd;
		logic take_prev;
		logic take_head;
		logic valid_nxt;
	} cell_ctl_t;

	// Capacity register value as used: zero acts as one, above ENTRIES saturates
	function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] reg_val);
		if (reg_val == '0)
			return CNT_W'(1);
		if (32'(reg_val) > ENTRIES)
			return CNT_W'(ENTRIES);
		return CNT_W'(reg_val);
	endfunction

endpackage

### hw/rtl/lkv_cell.sv
// One cell of the recency chain: holds an entry and compares its key.
module lkv_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lkv_pkg::cell_ctl_t           ctl,
	input  lkv_pkg::entry_t              prev_entry,
	input  lkv_pkg::entry_t              head_entry,
	input  logic [lkv_pkg::KEY_BITS-1:0] lookup_key,
	output lkv_pkg::entry_t              entry,
	output logic                         valid,
	output logic                         match
);
	import lkv_pkg::*;

	entry_t entry_q;
	logic   valid_q;

	// Valid bit, rewritten on every update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ctl.upd)
			valid_q <= ctl.valid_nxt;
	end

	// Entry payload: new head or shift from the more recent neighbour
	always_ff @(posedge clk) begin
		if (ctl.take_head)
			entry_q <= head_entry;
		else if (ctl.take_prev)
			entry_q <= prev_entry;
	end

	assign match = valid_q && (entry_q.key == lookup_key);
	assign entry = entry_q;
	assign valid = valid_q;

endmodule

### hw/rtl/lkv_regs.sv
// APB register block holding the capacity setting.
module lkv_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkv_pkg::ADDR_W-1:0]  paddr,
	input  logic [lkv_pkg::DATA_W-1:0]  pwdata,
	output logic [lkv_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [lkv_pkg::CNT_W-1:0]   cap
);
	import lkv_pkg::*;

	logic [CFG_W-1:0] cap_q;
	logic             sel_cap;

	assign sel_cap = (paddr[ADDR_W-1:2] == REG_CAP_IDX);

	// Capacity register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= CAP_RESET;
		else if (psel && penable && pwrite && sel_cap)
			cap_q <= pwdata[CFG_W-1:0];
	end

	// Read back
	assign prdata = sel_cap ? DATA_W'(cap_q) : '0;
	assign pready = 1'b1;
	assign cap    = clamp_cap(cap_q);

endmodule

### hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
//
// Channel   Dir  Handshake            Payload
// request   in   in_valid/in_ready    req_type, lookup_key, store_value
// result    out  out_valid/out_ready  hit, read_value, occupancy
// config    in   APB psel/penable     paddr, pwdata, prdata (capacity at 0x0)
//
// Each request passes a compare state for the parallel key compare across all
// cells, then an update state that shifts the recency chain (cell 0 is most recent).
// A new request is taken in the update cycle of the previous one.
// The update cycle stalls while the output register holds an untaken result.
// Reset clears valid bits and occupancy at once; no clearing pass is needed.
`include "assert_macros.svh"

module lru_key_value_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [lkv_pkg::KEY_BITS-1:0]   lookup_key,
	input  logic [lkv_pkg::VALUE_BITS-1:0] store_value,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [lkv_pkg::VALUE_BITS-1:0] read_value,
	output logic [lkv_pkg::CNT_W-1:0]      occupancy,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lkv_pkg::ADDR_W-1:0]     paddr,
	input  logic [lkv_pkg::DATA_W-1:0]     pwdata,
	output logic [lkv_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import lkv_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	state_t                state_q;
	req_t                  req_type_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [ENTRIES-1:0]    match_s1;
	logic [CNT_W-1:0]      eff_s1;
	logic [CNT_W-1:0]      cap_s1;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic [CNT_W-1:0]      occupancy_q;

	logic [CNT_W-1:0]      cap;
	logic [CNT_W-1:0]      eff_count;
	entry_t                entries [ENTRIES];
	logic [ENTRIES-1:0]    valid_vec;
	logic [ENTRIES-1:0]    match_vec;
	logic [ENTRIES-1:0]    suffix;
	cell_ctl_t             ctl [ENTRIES];
	entry_t                head_entry;
	logic [VALUE_BITS-1:0] sel_value;
	logic                  hit_any;
	logic                  out_free;
	logic                  upd_go;
	logic                  move_hit;
	logic                  put_miss;
	logic [CNT_W-1:0]      new_count;

	// Configuration registers
	lkv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap     (cap)
	);

	// Handshake
	assign out_free = !out_valid_q || out_ready;
	assign upd_go   = (state_q == ST_UPD) && out_free;
	assign in_ready = (state_q == ST_IDLE) || upd_go;

	// Occupancy after trimming to the capacity in use
	assign eff_count = (count_q > cap) ? cap : count_q;

	// Value of the hit cell
	always_comb begin
		sel_value = '0;
		for (int i = 0; i < ENTRIES; i++)
			sel_value = sel_value | (match_s1[i] ? entries[i].value : '0);
	end

	// Cells from the most recent down to the hit cell move one place
	always_comb begin
		for (int i = 0; i < ENTRIES; i++)
			suffix[i] = |(match_s1 & (ENTRIES'({ENTRIES{1'b1}}) << i));
	end

	assign hit_any  = |match_s1;
	assign move_hit = hit_any && (req_type_q == REQ_GET || req_type_q == REQ_PUT);
	assign put_miss = !hit_any && (req_type_q == REQ_PUT);

	assign head_entry.key   = key_q;
	assign head_entry.value = (req_type_q == REQ_PUT) ? value_q : sel_value;

	// Occupancy after this request
	always_comb begin
		unique case (req_type_q)
			REQ_FLUSH: new_count = '0;
			REQ_PUT: begin
				if (!hit_any && eff_s1 != cap_s1)
					new_count = eff_s1 + CNT_W'(1);
				else
					new_count = eff_s1;
			end
			default: new_count = eff_s1;
		endcase
	end

	// Chain of cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		assign ctl[i].upd       = upd_go;
		assign ctl[i].take_head = upd_go && (i == 0) && (move_hit || put_miss);
		assign ctl[i].take_prev = upd_go && (i != 0) && (put_miss || (move_hit && suffix[i]));
		assign ctl[i].valid_nxt = (CNT_W'(i) < new_count);

		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[i]),
			.prev_entry ((i == 0) ? head_entry : entries[(i == 0) ? 0 : i - 1]),
			.head_entry (head_entry),
			.lookup_key (key_q),
			.entry      (entries[i]),
			.valid      (valid_vec[i]),
			.match      (match_vec[i])
		);
	end

	// Sequencer, compare stage and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_type_q   <= REQ_GET;
			key_q        <= '0;
			value_q      <= '0;
			match_s1     <= '0;
			eff_s1       <= '0;
			cap_s1       <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			read_value_q <= '0;
			occupancy_q  <= '0;
		end else begin
			// Result valid: set on update, cleared once taken
			if (upd_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_type_q <= req_t'(req_type);
						key_q      <= lookup_key;
						value_q    <= store_value;
						state_q    <= ST_CMP;
					end
				end
				ST_CMP: begin
					for (int i = 0; i < ENTRIES; i++)
						match_s1[i] <= match_vec[i] && (CNT_W'(i) < cap);
					eff_s1  <= eff_count;
					cap_s1  <= cap;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) begin
						count_q      <= new_count;
						hit_q        <= hit_any && (req_type_q != REQ_FLUSH);
						read_value_q <= (req_type_q == REQ_GET && hit_any) ? sel_value : '0;
						occupancy_q  <= new_count;
						if (in_valid) begin
							req_type_q <= req_t'(req_type);
							key_q      <= lookup_key;
							value_q    <= store_value;
							state_q    <= ST_CMP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign occupancy  = occupancy_q;

	// Checks
	`ASSERT_ALWAYS(a_valid_count, clk, arst_n, $countones(valid_vec) == count_q)
	`ASSERT_IMPLY(a_single_hit, clk, arst_n, state_q == ST_UPD, $onehot0(match_s1))
	`ASSERT_NEXT(a_accept_cmp, clk, arst_n, in_valid && in_ready, state_q == ST_CMP)
	`ASSERT_NEXT(a_put_fills, clk, arst_n, upd_go && req_type_q == REQ_PUT, count_q != '0)

endmodule

### tb/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key/value cache: directed and random requests.
module tb_lru_key_value_cache;
	import lkv_pkg::*;

	localparam logic [ADDR_W-1:0] CAP_ADDR       = {REG_CAP_IDX, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_ADDR     = ADDR_W'(4);
	localparam int                PHASES         = 12;
	localparam int                HALF_ITEMS     = 65;
	localparam int                POOL_SIZE      = 24;
	localparam int                HOLD_PHASE     = 2;
	localparam int                HOLD_CYCLES    = 150;
	localparam int                SETTLE_CYCLES  = 4;
	localparam int                WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		req_t                  op;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} cache_req_t;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] rd;
		logic [CNT_W-1:0]      occ;
	} lookup_result_t;

	// clock, reset and block ports
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [1:0]            req_type    = 2'b00;
	logic [KEY_BITS-1:0]   lookup_key  = '0;
	logic [VALUE_BITS-1:0] store_value = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic [CNT_W-1:0]      occupancy;
	logic                  psel        = 1'b0;
	logic                  penable     = 1'b0;
	logic                  pwrite      = 1'b0;
	logic [ADDR_W-1:0]     paddr       = '0;
	logic [DATA_W-1:0]     pwdata      = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	// shadow copy of the cache contents
	logic                  cache_valid [ENTRIES];
	logic [KEY_BITS-1:0]   cache_key   [ENTRIES];
	logic [VALUE_BITS-1:0] cache_val   [ENTRIES];
	int unsigned           cache_rank  [ENTRIES];
	int unsigned           cache_count;
	logic [CFG_W-1:0]      cap_reg;

	cache_req_t            pending_q[$];
	lookup_result_t        result_q[$];
	logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];

	bit                    req_accepted   = 1'b0;
	int unsigned           quiet_cycles   = 0;
	int unsigned           mismatch_count = 0;
	int unsigned           send_idle_pct  = 8;
	int unsigned           recv_stall_pct = 54;
	int                    phase_idx      = -1;
	int unsigned           hold_left      = 0;
	bit                    hold_done      = 1'b0;

	lru_key_value_cache u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.read_value  (read_value),
		.occupancy   (occupancy),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #2 clk = ~clk;

	// Drop the least recent entry
	function automatic void drop_oldest();
		int i;
		if (cache_count == 0)
			return;
		for (i = 0; i < ENTRIES; i++) begin
			if (cache_valid[i] && cache_rank[i] == cache_count - 1) begin
				cache_valid[i] = 1'b0;
				cache_count--;
				return;
			end
		end
	endfunction

	// Make one entry the most recent, ageing those that were newer
	function automatic void promote(int slot);
		int          i;
		int unsigned r;
		r = cache_rank[slot];
		for (i = 0; i < ENTRIES; i++)
			if (cache_valid[i] && cache_rank[i] < r)
				cache_rank[i]++;
		cache_rank[slot] = 0;
	endfunction

	// Apply one request to the shadow cache and return the result it gives
	function automatic lookup_result_t cache_apply(cache_req_t rq);
		lookup_result_t res;
		int unsigned    cap;
		int             slot;
		int             free_slot;
		int             i;
		res = '0;
		cap = (cap_reg == '0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
		// trim after a lowered capacity
		while (cache_count > cap)
			drop_oldest();
		if (rq.op == REQ_FLUSH) begin
			for (i = 0; i < ENTRIES; i++)
				cache_valid[i] = 1'b0;
			cache_count = 0;
		end else begin
			slot = -1;
			for (i = ENTRIES - 1; i >= 0; i--)
				if (cache_valid[i] && cache_key[i] == rq.key)
					slot = i;
			res.hit = (slot >= 0);
			case (rq.op)
				REQ_GET: begin
					if (slot >= 0) begin
						promote(slot);
						res.rd = cache_val[slot];
					end
				end
				REQ_PUT: begin
					if (slot >= 0) begin
						cache_val[slot] = rq.value;
						promote(slot);
					end else begin
						if (cache_count >= cap)
							drop_oldest();
						// new key goes into the lowest free slot
						free_slot = -1;
						for (i = ENTRIES - 1; i >= 0; i--)
							if (!cache_valid[i])
								free_slot = i;
						if (free_slot >= 0) begin
							for (i = 0; i < ENTRIES; i++)
								if (cache_valid[i])
									cache_rank[i]++;
							cache_valid[free_slot] = 1'b1;
							cache_key[free_slot]   = rq.key;
							cache_val[free_slot]   = rq.value;
							cache_rank[free_slot]  = 0;
							cache_count++;
						end
					end
				end
				default: ;
			endcase
		end
		res.occ = cache_count[CNT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatch_count++;
	endtask

	task automatic push_req(req_t op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
		cache_req_t rq;
		rq.op    = op;
		rq.key   = key;
		rq.value = value;
		pending_q.insert(pending_q.size(), rq);
	endtask

	// Setup cycle, then access cycle; the register takes the data once pready is seen
	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == CAP_ADDR)
			cap_reg = data[CFG_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Hold until every request is sent and answered, then let the block settle
	task automatic wait_drained();
		while (pending_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Request driver
	always @(negedge clk) begin
		cache_req_t next_req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_accepted) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending_q.pop_front();
				in_valid    <= 1'b1;
				req_type    <= next_req.op;
				lookup_key  <= next_req.key;
				store_value <= next_req.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (phase_idx == HOLD_PHASE && !hold_done && out_valid) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: check results, predict accepted requests, track progress
	always @(posedge clk) begin
		lookup_result_t want;
		cache_req_t     taken;
		req_accepted = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(occupancy), 64'd0);
			end else begin
				want = result_q.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", 64'(hit), 64'(want.hit));
				if (read_value !== want.rd)
					report_mismatch("read_value", read_value, want.rd);
				if (occupancy !== want.occ)
					report_mismatch("occupancy", 64'(occupancy), 64'(want.occ));
			end
		end
		if (req_accepted) begin
			taken.op    = req_t'(req_type);
			taken.key   = lookup_key;
			taken.value = store_value;
			result_q.insert(result_q.size(), cache_apply(taken));
		end
		if (req_accepted || (out_valid && out_ready) || (psel && penable && pwrite && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// Watchdog
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("tb_lru_key_value_cache NOT OK");
		$finish;
	end

	// Stimulus
	initial begin
		int unsigned ph;
		int unsigned half;
		int unsigned n;
		int unsigned r;
		int unsigned span;
		int unsigned c;
		int          i;
		logic [CFG_W-1:0]      phase_caps [PHASES];
		req_t                  op;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;

		phase_caps = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd3, 5'd17, 5'd8, 5'd2, 5'd16, 5'd12,
			5'd4};
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		cap_reg     = CAP_RESET;
		cache_count = 0;
		for (i = 0; i < ENTRIES; i++)
			cache_valid[i] = 1'b0;

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// basic hits and misses at the reset capacity, extreme keys and values
		push_req(REQ_FLUSH, 32'h0000_0000, 64'h0);
		push_req(REQ_GET,   32'h0000_0000, 64'h0);
		push_req(REQ_PROBE, 32'hFFFF_FFFF, 64'h0);
		push_req(REQ_PUT,   32'h0000_0000, '1);
		push_req(REQ_PUT,   32'hFFFF_FFFF, 64'h0);
		push_req(REQ_PUT,   32'h5A5A_5A5A, 64'h0123_4567_89AB_CDEF);
		push_req(REQ_GET,   32'h0000_0000, 64'h0);
		push_req(REQ_PROBE, 32'hFFFF_FFFF, '1);
		push_req(REQ_PUT,   32'hFFFF_FFFF, 64'hA5A5_5A5A_F0F0_0F0F);
		push_req(REQ_GET,   32'hFFFF_FFFF, 64'h0);
		push_req(REQ_GET,   32'h1234_5678, 64'h0);
		push_req(REQ_FLUSH, 32'hFFFF_FFFF, '1);
		push_req(REQ_GET,   32'h0000_0000, 64'h0);
		wait_drained();

		// capacity of two; a write to an unused address must leave it alone
		write_reg(CAP_ADDR, 32'd2);
		write_reg(SPARE_ADDR, 32'd1);
		push_req(REQ_PUT,   32'h0000_0011, 64'h11);
		push_req(REQ_PUT,   32'h0000_0022, 64'h22);
		push_req(REQ_PUT,   32'h0000_0033, 64'h33);
		push_req(REQ_GET,   32'h0000_0011, 64'h0);
		push_req(REQ_GET,   32'h0000_0022, 64'h0);
		push_req(REQ_PUT,   32'h0000_0044, 64'h44);
		push_req(REQ_PROBE, 32'h0000_0033, 64'h0);
		wait_drained();

		// oversized capacity, fill a few, then drop to zero so the next request trims
		write_reg(CAP_ADDR, 32'd31);
		push_req(REQ_PUT,   32'h0000_0055, 64'h55);
		push_req(REQ_PUT,   32'h0000_0066, 64'h66);
		push_req(REQ_PUT,   32'h0000_0077, 64'h77);
		wait_drained();
		write_reg(CAP_ADDR, 32'd0);
		push_req(REQ_GET,   32'h0000_0077, 64'h0);
		push_req(REQ_GET,   32'h0000_0044, 64'h0);
		push_req(REQ_FLUSH, 32'h0000_0000, 64'h0);
		wait_drained();

		// random phases over a range of capacities and idling patterns
		for (ph = 0; ph < PHASES; ph++) begin
			write_reg(CAP_ADDR, DATA_W'(phase_caps[ph]));
			send_idle_pct  = (ph < 4) ? 8 : ((ph < 8) ? 54 : 0);
			recv_stall_pct = (ph < 4) ? 54 : ((ph < 8) ? 8 : 0);
			phase_idx      = ph;
			c    = phase_caps[ph];
			c    = (c == 0) ? 1 : ((c > ENTRIES) ? ENTRIES : c);
			span = (c + 4 > POOL_SIZE) ? POOL_SIZE : c + 4;
			for (half = 0; half < 2; half++) begin
				for (n = 0; n < HALF_ITEMS; n++) begin
					r  = $urandom_range(99);
					op = (r < 42) ? REQ_GET : ((r < 82) ? REQ_PUT :
						((r < 98) ? REQ_PROBE : REQ_FLUSH));
					key = ($urandom_range(9) == 0) ? KEY_BITS'($urandom) :
						key_pool[$urandom_range(span - 1)];
					r = $urandom_range(9);
					value = (r == 0) ? '0 : ((r == 1) ? '1 : {$urandom, $urandom});
					push_req(op, key, value);
				end
				// sender pauses until every request is answered
				wait_drained();
			end
		end

		repeat (8)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("tb_lru_key_value_cache OK");
		else
			$display("tb_lru_key_value_cache NOT OK");
		$finish;
	end

endmodule
